### hw/rtl/skt_pkg.sv
// Shared types and constants of the sorted key table.
`default_nettype none

package skt_pkg;

  localparam int KEY_W    = 31;
  localparam int TAG_W    = 32;
  localparam int POS_W    = 7;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_LIST   = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_INVALID   = 3'd3,
    ST_FULL      = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp_en;     // capture compare flags against the request key
    logic ins_en;     // open a slot at the boundary and write the new entry
    logic del_en;     // close the slot at the boundary
    logic tok_init;   // put the list token on the head cell
    logic tok_shift;  // hand the list token to the next cell
    logic list_mode;  // select by token instead of by boundary
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/skt_cell.sv
// One cell of the sorted chain: one entry, its compare flags and the list token.
`default_nettype none

module skt_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  skt_pkg::cell_ctrl_t            ctrl_i,
  input  logic                           occ_i,
  input  logic                           head_i,
  input  logic [skt_pkg::KEY_W-1:0]      key_i,
  input  logic [skt_pkg::TAG_W-1:0]      tag_i,
  input  logic                           prev_gt_i,
  input  logic                           prev_tok_i,
  input  logic [skt_pkg::KEY_W-1:0]      prev_key_i,
  input  logic [skt_pkg::TAG_W-1:0]      prev_tag_i,
  input  logic [skt_pkg::KEY_W-1:0]      next_key_i,
  input  logic [skt_pkg::TAG_W-1:0]      next_tag_i,
  output logic                           gt_o,
  output logic                           eq_o,
  output logic                           sel_o,
  output logic                           tok_o,
  output logic [skt_pkg::KEY_W-1:0]      key_o,
  output logic [skt_pkg::TAG_W-1:0]      tag_o
);

  logic [skt_pkg::KEY_W-1:0] key_q, key_d;
  logic [skt_pkg::TAG_W-1:0] tag_q, tag_d;
  logic                      gt_q, gt_d;
  logic                      eq_q, eq_d;
  logic                      tok_q, tok_d;
  logic                      bnd;

  // First cell whose key is not larger than the request key.
  assign bnd = prev_gt_i & ~gt_q;

  always_comb begin
    gt_d  = gt_q;
    eq_d  = eq_q;
    tok_d = tok_q;
    key_d = key_q;
    tag_d = tag_q;
    if (ctrl_i.cmp_en) begin
      gt_d = occ_i & (key_q > key_i);
      eq_d = occ_i & (key_q == key_i);
    end
    if (ctrl_i.tok_init) begin
      tok_d = head_i;
    end else if (ctrl_i.tok_shift) begin
      tok_d = prev_tok_i;
    end
    if (ctrl_i.ins_en && !gt_q) begin
      if (bnd) begin
        key_d = key_i;
        tag_d = tag_i;
      end else begin
        key_d = prev_key_i;
        tag_d = prev_tag_i;
      end
    end else if (ctrl_i.del_en && !gt_q) begin
      key_d = next_key_i;
      tag_d = next_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q  <= 1'b0;
      eq_q  <= 1'b0;
      tok_q <= 1'b0;
    end else begin
      gt_q  <= gt_d;
      eq_q  <= eq_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign gt_o  = gt_q;
  assign eq_o  = eq_q;
  assign tok_o = tok_q;
  assign sel_o = ctrl_i.list_mode ? tok_q : bnd;
  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

`default_nettype wire

### hw/rtl/skt_readout.sv
// Two-level registered OR tree that reads out the one selected cell.
`default_nettype none

module skt_readout #(
  parameter int N     = 64,
  parameter int IDX_W = 6
) (
  input  logic                      clk_i,
  input  logic [N-1:0]              sel_i,
  input  logic [N-1:0]              eq_i,
  input  logic [skt_pkg::KEY_W-1:0] key_i [N],
  input  logic [skt_pkg::TAG_W-1:0] tag_i [N],
  output logic                      hit_o,
  output logic                      eq_o,
  output logic [skt_pkg::KEY_W-1:0] key_o,
  output logic [skt_pkg::TAG_W-1:0] tag_o,
  output logic [IDX_W-1:0]          idx_o
);

  localparam int Grp = 8;
  localparam int G   = (N + Grp - 1) / Grp;

  logic                      l1_hit_d [G];
  logic                      l1_eq_d  [G];
  logic [skt_pkg::KEY_W-1:0] l1_key_d [G];
  logic [skt_pkg::TAG_W-1:0] l1_tag_d [G];
  logic [IDX_W-1:0]          l1_idx_d [G];
  logic                      l1_hit_q [G];
  logic                      l1_eq_q  [G];
  logic [skt_pkg::KEY_W-1:0] l1_key_q [G];
  logic [skt_pkg::TAG_W-1:0] l1_tag_q [G];
  logic [IDX_W-1:0]          l1_idx_q [G];

  logic                      l2_hit_d, l2_eq_d;
  logic [skt_pkg::KEY_W-1:0] l2_key_d;
  logic [skt_pkg::TAG_W-1:0] l2_tag_d;
  logic [IDX_W-1:0]          l2_idx_d;

  // Leaf groups of eight cells.
  always_comb begin
    int k;
    for (int g = 0; g < G; g++) begin
      l1_hit_d[g] = 1'b0;
      l1_eq_d[g]  = 1'b0;
      l1_key_d[g] = '0;
      l1_tag_d[g] = '0;
      l1_idx_d[g] = '0;
      for (int j = 0; j < Grp; j++) begin
        k = g * Grp + j;
        if (k < N) begin
          if (sel_i[k]) begin
            l1_hit_d[g] = 1'b1;
            l1_eq_d[g]  = l1_eq_d[g] | eq_i[k];
            l1_key_d[g] = l1_key_d[g] | key_i[k];
            l1_tag_d[g] = l1_tag_d[g] | tag_i[k];
            l1_idx_d[g] = l1_idx_d[g] | IDX_W'(k);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < G; g++) begin
      l1_hit_q[g] <= l1_hit_d[g];
      l1_eq_q[g]  <= l1_eq_d[g];
      l1_key_q[g] <= l1_key_d[g];
      l1_tag_q[g] <= l1_tag_d[g];
      l1_idx_q[g] <= l1_idx_d[g];
    end
  end

  // Root over the groups.
  always_comb begin
    l2_hit_d = 1'b0;
    l2_eq_d  = 1'b0;
    l2_key_d = '0;
    l2_tag_d = '0;
    l2_idx_d = '0;
    for (int g = 0; g < G; g++) begin
      l2_hit_d = l2_hit_d | l1_hit_q[g];
      l2_eq_d  = l2_eq_d  | l1_eq_q[g];
      l2_key_d = l2_key_d | l1_key_q[g];
      l2_tag_d = l2_tag_d | l1_tag_q[g];
      l2_idx_d = l2_idx_d | l1_idx_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o <= l2_hit_d;
    eq_o  <= l2_eq_d;
    key_o <= l2_key_d;
    tag_o <= l2_tag_d;
    idx_o <= l2_idx_d;
  end

endmodule

`default_nettype wire

### hw/rtl/sorted_key_table_core.sv
// Top level of the sorted key table: cell chain, readout tree, sequencer, output register.
//
// Usage: a table of up to CAPACITY unique nonzero keys with 32-bit tags, kept
// in descending key order in a chain of cells, one entry per cell.
// Request channel s_axis: tuser carries the request type (insert, delete,
// search, list), tdata the key and the tag. Result channel m_axis: tuser
// carries the status, tdata the key, tag and one-based position, tlast marks
// the final result of a request.
// Each request runs one at a time: the accept state, a compare state in which
// every cell compares its key, the states S_RD1 and S_RD2 through the
// registered readout tree, and a result state that writes the result register
// and shifts the chain. A new request is taken only once the sequencer is back
// in idle, never while another request is still in progress.
// A list returns through S_RD1, S_RD2 and the result state for each further
// entry, after the list token moves to the next cell.
// The request channel is ready again while the last result still sits in the
// output register.
// A stalled receiver holds the sequencer in its result cycle; nothing is lost.
// Reset empties the table (entry count to zero) at once; no clearing pass.
`default_nettype none

module sorted_key_table_core #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  input  logic [63:0] s_axis_tdata,   // [30:0] key, [62:31] record_tag, [63] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic [71:0] m_axis_tdata,   // [30:0] out_key, [62:31] out_tag, [69:63] position
  output logic        m_axis_tlast    // last
);

  localparam int KeyW = skt_pkg::KEY_W;
  localparam int TagW = skt_pkg::TAG_W;
  localparam int PosW = skt_pkg::POS_W;
  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_RD1  = 5'b00100,
    S_RD2  = 5'b01000,
    S_RES  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Request held for the whole operation.
  skt_pkg::req_e   req_q;
  logic [KeyW-1:0] rkey_q;
  logic [TagW-1:0] rtag_q;
  logic [CntW-1:0] count_q, count_d;

  // Output register.
  logic                     m_valid_q, m_valid_d;
  skt_pkg::status_e         m_status_q, m_status_d;
  logic [KeyW-1:0]          m_key_q, m_key_d;
  logic [TagW-1:0]          m_tag_q, m_tag_d;
  logic [PosW-1:0]          m_pos_q, m_pos_d;
  logic                     m_last_q, m_last_d;
  logic                     out_free;

  // Chain wiring.
  skt_pkg::cell_ctrl_t ctrl;
  logic [CAPACITY-1:0] cell_gt, cell_eq, cell_sel, cell_tok, cell_occ;
  logic [KeyW-1:0]     cell_key [CAPACITY];
  logic [TagW-1:0]     cell_tag [CAPACITY];

  // Readout of the selected cell.
  logic            rd_hit, rd_eq;
  logic [KeyW-1:0] rd_key;
  logic [TagW-1:0] rd_tag;
  logic [IdxW-1:0] rd_idx;
  logic [PosW-1:0] rd_pos;
  logic            rd_last;

  // Result decision.
  skt_pkg::status_e res_status;
  logic [KeyW-1:0]  res_key;
  logic [TagW-1:0]  res_tag;
  logic [PosW-1:0]  res_pos;
  logic             res_last;
  logic             do_ins, do_del, list_more;
  logic             tbl_empty, tbl_full;

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = ~m_valid_q | m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q  <= skt_pkg::req_e'(s_axis_tuser);
      rkey_q <= s_axis_tdata[KeyW-1:0];
      rtag_q <= s_axis_tdata[KeyW+TagW-1:KeyW];
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain. Cell 0 holds the largest key; cells at or beyond the count
  // hold stale data and are masked by the occupancy thermometer.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            prev_gt, prev_tok;
    logic [KeyW-1:0] prev_key, next_key;
    logic [TagW-1:0] prev_tag, next_tag;

    assign cell_occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b1;
      assign prev_tok = 1'b0;
      assign prev_key = rkey_q;
      assign prev_tag = rtag_q;
    end else begin : g_body
      assign prev_gt  = cell_gt[i-1];
      assign prev_tok = cell_tok[i-1];
      assign prev_key = cell_key[i-1];
      assign prev_tag = cell_tag[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key = cell_key[i];
      assign next_tag = cell_tag[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
      assign next_tag = cell_tag[i+1];
    end

    skt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .occ_i      (cell_occ[i]),
      .head_i     ((i == 0) ? 1'b1 : 1'b0),
      .key_i      (rkey_q),
      .tag_i      (rtag_q),
      .prev_gt_i  (prev_gt),
      .prev_tok_i (prev_tok),
      .prev_key_i (prev_key),
      .prev_tag_i (prev_tag),
      .next_key_i (next_key),
      .next_tag_i (next_tag),
      .gt_o       (cell_gt[i]),
      .eq_o       (cell_eq[i]),
      .sel_o      (cell_sel[i]),
      .tok_o      (cell_tok[i]),
      .key_o      (cell_key[i]),
      .tag_o      (cell_tag[i])
    );
  end

  skt_readout #(
    .N     (CAPACITY),
    .IDX_W (IdxW)
  ) u_readout (
    .clk_i (clk_i),
    .sel_i (cell_sel),
    .eq_i  (cell_eq),
    .key_i (cell_key),
    .tag_i (cell_tag),
    .hit_o (rd_hit),
    .eq_o  (rd_eq),
    .key_o (rd_key),
    .tag_o (rd_tag),
    .idx_o (rd_idx)
  );

  assign rd_pos    = PosW'(rd_idx) + PosW'(1);
  assign rd_last   = (CntW'(rd_idx) + CntW'(1)) == count_q;
  assign tbl_empty = (count_q == '0);
  assign tbl_full  = (count_q == CntW'(CAPACITY));

  // ---------------------------------------------------------------------------
  // Result of the current request, from the boundary cell (or the token cell
  // when listing). The boundary cell is the matching entry when the key is
  // present, otherwise the slot where the key would be placed.
  // ---------------------------------------------------------------------------
  always_comb begin
    res_status = skt_pkg::ST_OK;
    res_key    = '0;
    res_tag    = '0;
    res_pos    = '0;
    res_last   = 1'b1;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    list_more  = 1'b0;
    unique case (req_q)
      skt_pkg::REQ_INSERT: begin
        if (rkey_q == '0) begin
          res_status = skt_pkg::ST_INVALID;
        end else if (rd_hit && rd_eq) begin
          res_status = skt_pkg::ST_DUPLICATE;
          res_key    = rd_key;
          res_tag    = rd_tag;
          res_pos    = rd_pos;
        end else if (tbl_full) begin
          res_status = skt_pkg::ST_FULL;
        end else begin
          res_key = rkey_q;
          res_tag = rtag_q;
          res_pos = rd_pos;
          do_ins  = 1'b1;
        end
      end
      skt_pkg::REQ_DELETE, skt_pkg::REQ_SEARCH: begin
        if (tbl_empty) begin
          res_status = skt_pkg::ST_EMPTY;
        end else if (!(rd_hit && rd_eq)) begin
          res_status = skt_pkg::ST_NOT_FOUND;
        end else begin
          res_key = rd_key;
          res_tag = rd_tag;
          res_pos = rd_pos;
          do_del  = (req_q == skt_pkg::REQ_DELETE);
        end
      end
      skt_pkg::REQ_LIST: begin
        if (tbl_empty) begin
          res_status = skt_pkg::ST_EMPTY;
        end else begin
          res_key   = rd_key;
          res_tag   = rd_tag;
          res_pos   = rd_pos;
          res_last  = rd_last;
          list_more = ~rd_last;
        end
      end
      default: begin
        res_status = skt_pkg::ST_OK;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    ctrl           = '0;
    ctrl.list_mode = (req_q == skt_pkg::REQ_LIST);
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.cmp_en   = 1'b1;
        ctrl.tok_init = 1'b1;
        state_d       = S_RD1;
      end
      S_RD1: begin
        state_d = S_RD2;
      end
      S_RD2: begin
        state_d = S_RES;
      end
      S_RES: begin
        // Hold here while the output register is still occupied.
        if (out_free) begin
          ctrl.ins_en = do_ins;
          ctrl.del_en = do_del;
          if (do_ins) begin
            count_d = count_q + CntW'(1);
          end else if (do_del) begin
            count_d = count_q - CntW'(1);
          end
          if (list_more) begin
            ctrl.tok_shift = 1'b1;
            state_d        = S_RD1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d  = m_valid_q & ~m_axis_tready;
    m_status_d = m_status_q;
    m_key_d    = m_key_q;
    m_tag_d    = m_tag_q;
    m_pos_d    = m_pos_q;
    m_last_d   = m_last_q;
    if (state_q == S_RES && out_free) begin
      m_valid_d  = 1'b1;
      m_status_d = res_status;
      m_key_d    = res_key;
      m_tag_d    = res_tag;
      m_pos_d    = res_pos;
      m_last_d   = res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_status_q <= m_status_d;
    m_key_q    <= m_key_d;
    m_tag_q    <= m_tag_d;
    m_pos_q    <= m_pos_d;
    m_last_q   <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {2'b00, m_pos_q, m_tag_q, m_key_q};
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTH
  // The entry count never exceeds the chain length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count beyond capacity");

  // At most one cell drives the readout tree.
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD1 |-> $onehot0(cell_sel))
    else $error("more than one cell selected for readout");

  // A committed insert grows the table by exactly one entry.
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES && out_free && do_ins) |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not advance the entry count");

  // Only a listed entry that is not the final one may leave tlast low.
  a_nonlast_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_last_q) |-> (m_status_q == skt_pkg::ST_OK && req_q == skt_pkg::REQ_LIST))
    else $error("non-final result outside a listing");
`endif

endmodule

`default_nettype wire

### sim/sorted_key_table_core_tb.sv
// Self-checking testbench for the sorted key table core: stream stimulus and a result scoreboard.
`default_nettype none

module sorted_key_table_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH       = 64;
  localparam int          RANDOM_REQS = 300;
  localparam int          DRAIN_CYCLES = 20;
  localparam int unsigned IDLE_LIMIT  = 3000;  // cycles without any transaction
  localparam logic [skt_pkg::KEY_W-1:0] KEY_MAX = {skt_pkg::KEY_W{1'b1}};

  // One expected result transaction on the master side.
  typedef struct {
    skt_pkg::status_e          status;
    logic [skt_pkg::KEY_W-1:0] key;
    logic [skt_pkg::TAG_W-1:0] tag;
    logic [skt_pkg::POS_W-1:0] position;
    logic                      last;
  } table_result_t;

  // Mirror of the table contents plus the queue of results still owed by the core.
  class table_tracker;
    logic [skt_pkg::KEY_W-1:0] slot_key [DEPTH];
    logic [skt_pkg::TAG_W-1:0] slot_tag [DEPTH];
    int                        fill;
    table_result_t             pending_results [$];
    int unsigned               errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void owe(skt_pkg::status_e st, logic [skt_pkg::KEY_W-1:0] k,
                      logic [skt_pkg::TAG_W-1:0] t, int pos, logic last);
      table_result_t r;
      r.status   = st;
      r.key      = k;
      r.tag      = t;
      r.position = skt_pkg::POS_W'(pos);
      r.last     = last;
      pending_results.push_back(r);
    endfunction

    function logic [skt_pkg::KEY_W-1:0] pick_stored_key();
      return slot_key[$urandom_range(0, fill - 1)];
    endfunction

    // Update the table copy for one accepted request and queue what it must produce.
    function void predict_request(skt_pkg::req_e req, logic [skt_pkg::KEY_W-1:0] key,
                                  logic [skt_pkg::TAG_W-1:0] tag);
      int hit;
      int at;
      hit = fill;
      for (int i = 0; i < fill; i++)
        if (hit == fill && slot_key[i] == key) hit = i;
      case (req)
        skt_pkg::REQ_INSERT: begin
          if (key == '0) begin
            owe(skt_pkg::ST_INVALID, '0, '0, 0, 1'b1);
          end else if (hit < fill) begin
            owe(skt_pkg::ST_DUPLICATE, slot_key[hit], slot_tag[hit], hit + 1, 1'b1);
          end else if (fill >= DEPTH) begin
            owe(skt_pkg::ST_FULL, '0, '0, 0, 1'b1);
          end else begin
            at = fill;
            for (int i = 0; i < fill; i++)
              if (at == fill && slot_key[i] < key) at = i;
            for (int j = fill; j > at; j--) begin
              slot_key[j] = slot_key[j-1];
              slot_tag[j] = slot_tag[j-1];
            end
            slot_key[at] = key;
            slot_tag[at] = tag;
            fill++;
            owe(skt_pkg::ST_OK, key, tag, at + 1, 1'b1);
          end
        end
        skt_pkg::REQ_DELETE, skt_pkg::REQ_SEARCH: begin
          if (fill == 0) begin
            owe(skt_pkg::ST_EMPTY, '0, '0, 0, 1'b1);
          end else if (hit >= fill) begin
            owe(skt_pkg::ST_NOT_FOUND, '0, '0, 0, 1'b1);
          end else begin
            owe(skt_pkg::ST_OK, slot_key[hit], slot_tag[hit], hit + 1, 1'b1);
            if (req == skt_pkg::REQ_DELETE) begin
              for (int j = hit; j + 1 < fill; j++) begin
                slot_key[j] = slot_key[j+1];
                slot_tag[j] = slot_tag[j+1];
              end
              fill--;
            end
          end
        end
        default: begin
          if (fill == 0) begin
            owe(skt_pkg::ST_EMPTY, '0, '0, 0, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++)
              owe(skt_pkg::ST_OK, slot_key[i], slot_tag[i], i + 1, (i + 1 == fill));
          end
        end
      endcase
    endfunction

    function void check_field(string name, logic [skt_pkg::TAG_W-1:0] expv,
                              logic [skt_pkg::TAG_W-1:0] actv);
      if (actv !== expv) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expv, actv);
        errors++;
      end
    endfunction

    // Compare one result transaction against the oldest expectation.
    function void compare_result(logic [2:0] st, logic [71:0] data, logic last);
      table_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d data %0h last %0b",
                 $time, st, data, last);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("status",   skt_pkg::TAG_W'(want.status),   skt_pkg::TAG_W'(st));
      check_field("key",      skt_pkg::TAG_W'(want.key),      skt_pkg::TAG_W'(data[30:0]));
      check_field("tag",      want.tag,                       data[62:31]);
      check_field("position", skt_pkg::TAG_W'(want.position), skt_pkg::TAG_W'(data[69:63]));
      check_field("last",     skt_pkg::TAG_W'(want.last),     skt_pkg::TAG_W'(last));
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] req_type
  logic [63:0] s_axis_tdata  = '0;   // [30:0] key, [62:31] record_tag, [63] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [2:0]  m_axis_tuser;         // [2:0] status
  logic [71:0] m_axis_tdata;         // [30:0] out_key, [62:31] out_tag, [69:63] position
  logic        m_axis_tlast;

  table_tracker tracker;
  int unsigned  send_calm = 0;       // remaining requests sent back to back
  int unsigned  recv_calm = 0;       // remaining results taken without stall
  int unsigned  idle_cycles = 0;

  sorted_key_table_core #(
    .CAPACITY(DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Draw the wait before the next transaction: usually a random gap, now and then a
  // calm stretch with no waiting at all.
  function automatic int unsigned draw_idle(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Offer one request after a random gap and hold it until the core takes it.
  // Leave tvalid high on return so a zero gap keeps the bus busy.
  task automatic issue_request(input skt_pkg::req_e req,
                               input logic [skt_pkg::KEY_W-1:0] key,
                               input logic [skt_pkg::TAG_W-1:0] tag);
    int unsigned gap;
    gap = draw_idle(send_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {1'b0, tag, key};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sample both channels at the clock edge; every value read here is the pre-edge one,
  // so a transaction counts exactly when the core sees it.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      tracker.predict_request(skt_pkg::req_e'(s_axis_tuser), s_axis_tdata[30:0],
                              s_axis_tdata[62:31]);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.compare_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // Abort when the bus goes quiet for far longer than the slowest legal request.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result receiver: stall a random number of cycles before each result transaction.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_idle(recv_calm);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    skt_pkg::req_e             op;
    logic [skt_pkg::KEY_W-1:0] k;
    int unsigned               roll;
    bit                        shrinking;

    tracker   = new();
    shrinking = 1'b0;

    // Hold reset low, then release it on a clock edge.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty-table answers, zero key, extreme keys and tags, duplicate,
    // hits and misses, deletes at head, middle and tail, and lists.
    issue_request(skt_pkg::REQ_LIST,   '0,       '0);
    issue_request(skt_pkg::REQ_SEARCH, 31'd5,    '0);
    issue_request(skt_pkg::REQ_DELETE, 31'd5,    '0);
    issue_request(skt_pkg::REQ_INSERT, '0,       32'h1234_5678);
    issue_request(skt_pkg::REQ_INSERT, KEY_MAX,  32'hFFFF_FFFF);
    issue_request(skt_pkg::REQ_INSERT, 31'd1,    32'h0000_0000);
    issue_request(skt_pkg::REQ_INSERT, 31'd1000, 32'hA5A5_A5A5);
    issue_request(skt_pkg::REQ_INSERT, 31'd1000, 32'h5A5A_5A5A);
    issue_request(skt_pkg::REQ_SEARCH, 31'd1,    '0);
    issue_request(skt_pkg::REQ_SEARCH, '0,       '0);
    issue_request(skt_pkg::REQ_SEARCH, 31'd77,   '0);
    issue_request(skt_pkg::REQ_DELETE, '0,       '0);
    issue_request(skt_pkg::REQ_DELETE, 31'd77,   '0);
    issue_request(skt_pkg::REQ_LIST,   '0,       '0);
    issue_request(skt_pkg::REQ_DELETE, 31'd1000, '0);
    issue_request(skt_pkg::REQ_DELETE, KEY_MAX,  '0);
    issue_request(skt_pkg::REQ_DELETE, 31'd1,    '0);
    issue_request(skt_pkg::REQ_LIST,   '0,       '0);
    issue_request(skt_pkg::REQ_INSERT, 31'h4000_0000, 32'h5A5A_5A5A);
    issue_request(skt_pkg::REQ_INSERT, 31'h2AAA_AAAA, 32'h8000_0001);
    issue_request(skt_pkg::REQ_INSERT, 31'h5555_5555, 32'h7FFF_FFFE);
    issue_request(skt_pkg::REQ_LIST,   '0,       '0);

    // Random part: alternate a growing phase (mostly inserts, left at random once the
    // table is full) with a shrinking phase (mostly deletes of stored keys, until it
    // is empty again).
    for (int n = 0; n < RANDOM_REQS; n++) begin
      roll = $urandom_range(0, 99);
      if (!shrinking)
        op = (roll < 65) ? skt_pkg::REQ_INSERT : (roll < 80) ? skt_pkg::REQ_SEARCH :
             (roll < 96) ? skt_pkg::REQ_DELETE : skt_pkg::REQ_LIST;
      else
        op = (roll < 10) ? skt_pkg::REQ_INSERT : (roll < 25) ? skt_pkg::REQ_SEARCH :
             (roll < 96) ? skt_pkg::REQ_DELETE : skt_pkg::REQ_LIST;

      // Lookups mostly hit stored keys; inserts mostly bring new ones.
      roll = $urandom_range(0, 99);
      if (tracker.fill > 0 && roll < ((op == skt_pkg::REQ_INSERT) ? 15 : 65))
        k = tracker.pick_stored_key();
      else if (roll < 70)
        k = skt_pkg::KEY_W'($urandom_range(1, 300));
      else if (roll < 75)
        k = '0;
      else if (roll < 78)
        k = KEY_MAX;
      else
        k = skt_pkg::KEY_W'($urandom);

      issue_request(op, k, $urandom);

      if (!shrinking && tracker.fill == DEPTH && $urandom_range(0, 3) == 0)
        shrinking = 1'b1;
      else if (shrinking && tracker.fill == 0)
        shrinking = 1'b0;
    end

    // Drop valid, let the last request reach the scoreboard, drain every owed
    // result, then watch a while for strays.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
